// ===== hdl/tfd_pkg.sv =====
package tfd_pkg;

	localparam logic [7:0] CRC_POLY = 8'h07;
	localparam int WIDX_W = 4;

	typedef enum logic {
		CFG_WRITE_ADDR = 1'b0,
		CFG_COMMAND    = 1'b1
	} tfd_cfg_idx_t;

	typedef enum logic {
		KIND_WORD = 1'b0,
		KIND_PEC  = 1'b1
	} tfd_kind_t;

	typedef struct packed {
		logic [7:0] rx_byte;
		logic       frame_start;
	} tfd_in_t;

	typedef struct packed {
		tfd_kind_t          result_kind;
		logic [WIDX_W-1:0]  word_index;
		logic signed [15:0] word_value;
		logic               pec_ok;
		logic [7:0]         crc_value;
	} tfd_out_t;

	typedef struct packed {
		tfd_cfg_idx_t index;
		logic [7:0]   value;
	} tfd_cfg_t;

	typedef struct packed {
		logic [7:0] crc;
		logic       ready;
	} tfd_prefix_t;

	function automatic logic [7:0] crc8_fold(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] r;
		r = crc ^ b;
		for (int k = 0; k < 8; k++) begin
			r = r[7] ? ({r[6:0], 1'b0} ^ CRC_POLY) : {r[6:0], 1'b0};
		end
		return r;
	endfunction

endpackage

// ===== hdl/tfd_chan_if.sv =====
interface tfd_chan_if #(parameter type T = logic) ();
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== hdl/thermal_frame_deframer_pec_core.sv =====
// A request is registered in v_s1/data_s1 and its result, if any, in out_q.
// Throughput: one request per cycle while not stalled by the output; the
// single-pass CRC fold sets the cycle. Reset clears frame state; rx.ready
// stays low after reset and after each configuration write while the prefix
// CRC pipeline refills. Configuration writes are taken every cycle.
module thermal_frame_deframer_pec_core import tfd_pkg::*; #(
	parameter int DATA_BYTES = 18
) (
	input  logic       clk,
	input  logic       arst_n,
	tfd_chan_if.sink   cfg,
	tfd_chan_if.sink   rx,
	tfd_chan_if.source result
);

	localparam int POS_W = $clog2(DATA_BYTES + 1);

	tfd_prefix_t pfx;

	tfd_prefix u_prefix (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.prefix (pfx)
	);

	logic             v_s1;
	tfd_in_t          data_s1;
	logic [7:0]       crc_q, crc_n, crc_base;
	logic [POS_W-1:0] pos_q, pos_n, pos_base;
	logic [7:0]       hold_q, hold_n;
	logic             active_q, active_n, active;
	logic             has_res;
	tfd_out_t         res_d;
	logic             out_v_q;
	tfd_out_t         out_q;
	logic             out_free, adv, load, rx_acc;

	assign out_free  = !out_v_q || result.ready;
	assign adv       = v_s1 && (!has_res || out_free);
	assign load      = adv && has_res;
	assign rx.ready  = pfx.ready && (!v_s1 || adv);
	assign rx_acc    = rx.valid && rx.ready;

	always_comb begin
		crc_base = data_s1.frame_start ? pfx.crc : crc_q;
		pos_base = data_s1.frame_start ? '0 : pos_q;
		active   = data_s1.frame_start | active_q;
		has_res  = 1'b0;
		res_d    = '0;
		crc_n    = crc_q;
		pos_n    = pos_q;
		hold_n   = hold_q;
		active_n = active_q;
		if (active) begin
			active_n = 1'b1;
			crc_n    = crc_base;
			pos_n    = pos_base;
			if (pos_base < POS_W'(DATA_BYTES)) begin
				crc_n = crc8_fold(crc_base, data_s1.rx_byte);
				pos_n = pos_base + 1'b1;
				if (!pos_base[0]) begin
					hold_n = data_s1.rx_byte;
				end else begin
					has_res           = 1'b1;
					res_d.result_kind = KIND_WORD;
					res_d.word_index  = WIDX_W'(pos_base >> 1);
					res_d.word_value  = {data_s1.rx_byte, hold_q};
				end
			end else begin
				has_res           = 1'b1;
				res_d.result_kind = KIND_PEC;
				res_d.pec_ok      = (crc_base == data_s1.rx_byte);
				res_d.crc_value   = crc_base;
				active_n          = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1     <= 1'b0;
			out_v_q  <= 1'b0;
			crc_q    <= '0;
			pos_q    <= '0;
			hold_q   <= '0;
			active_q <= 1'b0;
		end else begin
			if (rx_acc) begin
				v_s1 <= 1'b1;
			end else if (adv) begin
				v_s1 <= 1'b0;
			end
			if (load) begin
				out_v_q <= 1'b1;
			end else if (result.ready) begin
				out_v_q <= 1'b0;
			end
			if (adv) begin
				crc_q    <= crc_n;
				pos_q    <= pos_n;
				hold_q   <= hold_n;
				active_q <= active_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rx_acc) begin
			data_s1 <= rx.data;
		end
		if (load) begin
			out_q <= res_d;
		end
	end

	assign result.valid = out_v_q;
	assign result.data  = out_q;

	a_pos_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= POS_W'(DATA_BYTES))
		else $error("byte position beyond frame length");

	a_idle_silent: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && !data_s1.frame_start && !active_q |-> !load)
		else $error("result produced outside a frame");

	a_pec_closes: assert property (@(posedge clk) disable iff (!arst_n)
		load && (res_d.result_kind == KIND_PEC) |=> !active_q)
		else $error("frame still open after check byte");

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q && !result.ready |-> !load)
		else $error("result register overwritten while stalled");

endmodule

// ===== hdl/tfd_prefix.sv =====
module tfd_prefix import tfd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	tfd_chan_if.sink    cfg,
	output tfd_prefix_t prefix
);

	localparam logic [1:0] SETTLE = 2'd3;

	logic [7:0] wr_addr_q;
	logic [7:0] cmd_q;
	logic [7:0] c1_q;
	logic [7:0] c2_q;
	logic [7:0] pre_q;
	logic [1:0] settle_q;
	logic       wr;

	assign cfg.ready = 1'b1;
	assign wr = cfg.valid & cfg.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_addr_q <= 8'h14;
			cmd_q     <= 8'h4C;
			settle_q  <= SETTLE;
		end else begin
			if (wr) begin
				unique case (cfg.data.index)
					CFG_WRITE_ADDR: wr_addr_q <= cfg.data.value;
					CFG_COMMAND:    cmd_q     <= cfg.data.value;
					default:        ;
				endcase
				settle_q <= SETTLE;
			end else if (settle_q != 2'd0) begin
				settle_q <= settle_q - 2'd1;
			end
		end
	end

	// prefix: write address, command, read address
	always_ff @(posedge clk) begin
		c1_q  <= crc8_fold(8'h00, wr_addr_q);
		c2_q  <= crc8_fold(c1_q, cmd_q);
		pre_q <= crc8_fold(c2_q, wr_addr_q + 8'd1);
	end

	assign prefix.crc   = pre_q;
	assign prefix.ready = (settle_q == 2'd0);

endmodule

// ===== tb/thermal_frame_deframer_pec_check.sv =====
`timescale 1ns / 100ps

module thermal_frame_deframer_pec_check import tfd_pkg::*; #(
	parameter int DATA_BYTES = 18
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_valid,
	input  logic       cfg_ready,
	input  tfd_cfg_t   cfg_data,
	input  logic       rx_valid,
	input  logic       rx_ready,
	input  tfd_in_t    rx_data,
	input  logic       result_valid,
	input  logic       result_ready,
	input  tfd_out_t   result_data,
	output int         results_due,
	output int         failures,
	output logic [7:0] frame_crc
);

	localparam logic [7:0] RESET_WRITE_ADDR = 8'h14;
	localparam logic [7:0] RESET_COMMAND    = 8'h4C;

	logic [7:0] write_addr;
	logic [7:0] cmd_code;
	logic [4:0] data_count;
	logic [7:0] low_byte;
	logic       in_frame;
	tfd_out_t   frame_results_due[$];
	tfd_out_t   oldest;

	// serial form: one input bit per shift, MSB first
	function automatic logic [7:0] crc8_byte(input logic [7:0] acc, input logic [7:0] d);
		logic [7:0] c;
		c = acc;
		for (int i = 7; i >= 0; i--) begin
			if (c[7] ^ d[i])
				c = {c[6:0], 1'b0} ^ CRC_POLY;
			else
				c = {c[6:0], 1'b0};
		end
		return c;
	endfunction

	function automatic void take_byte(input tfd_in_t item);
		tfd_out_t r;
		r = '0;
		if (item.frame_start) begin
			frame_crc = crc8_byte(crc8_byte(crc8_byte(8'h00, write_addr), cmd_code),
				8'(write_addr + 8'd1));
			data_count = '0;
			low_byte = '0;
			in_frame = 1'b1;
		end
		if (!in_frame)
			return;
		if (data_count < DATA_BYTES) begin
			frame_crc = crc8_byte(frame_crc, item.rx_byte);
			if (!data_count[0]) begin
				low_byte = item.rx_byte;
				data_count = data_count + 5'd1;
				return;
			end
			r.result_kind = KIND_WORD;
			r.word_index = data_count[4:1];
			r.word_value = {item.rx_byte, low_byte};
			data_count = data_count + 5'd1;
		end else begin
			r.result_kind = KIND_PEC;
			r.pec_ok = (frame_crc == item.rx_byte);
			r.crc_value = frame_crc;
			in_frame = 1'b0;
		end
		frame_results_due.push_back(r);
	endfunction

	function automatic void check_field(input string field, input int want, input int got);
		if (want != got) begin
			failures++;
			$display("%0t: %s expected %0d, got %0d", $time, field, want, got);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			write_addr = RESET_WRITE_ADDR;
			cmd_code = RESET_COMMAND;
			frame_crc = '0;
			data_count = '0;
			low_byte = '0;
			in_frame = 1'b0;
			frame_results_due.delete();
			results_due = 0;
			failures = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_data.index)
				CFG_WRITE_ADDR: write_addr = cfg_data.value;
				CFG_COMMAND:    cmd_code = cfg_data.value;
				endcase
			end
			if (rx_valid && rx_ready)
				take_byte(rx_data);
			if (result_valid && result_ready) begin
				if (frame_results_due.size() == 0) begin
					failures++;
					$display("%0t: unexpected result, kind %0d index %0d value %0d crc %0d",
						$time, result_data.result_kind, result_data.word_index,
						$signed(result_data.word_value), result_data.crc_value);
				end else begin
					oldest = frame_results_due.pop_front();
					check_field("result_kind", oldest.result_kind, result_data.result_kind);
					check_field("word_index", oldest.word_index, result_data.word_index);
					check_field("word_value", $signed(oldest.word_value),
						$signed(result_data.word_value));
					check_field("pec_ok", oldest.pec_ok, result_data.pec_ok);
					check_field("crc_value", oldest.crc_value, result_data.crc_value);
				end
			end
			results_due = frame_results_due.size();
		end
	end

endmodule

// ===== tb/thermal_frame_deframer_pec_core_test.sv =====
`timescale 1ns / 100ps

module thermal_frame_deframer_pec_core_test;
	import tfd_pkg::*;

	localparam int DATA_BYTES      = 18;
	localparam int CYCLE_LIMIT     = 200000;
	localparam int LONG_HOLD       = 300;
	localparam int PHASES          = 6;
	localparam int ITEMS_PER_PHASE = 290;

	localparam logic [7:0] EXTREME_BYTES [DATA_BYTES] = '{
		8'h00, 8'h00, 8'hFF, 8'hFF, 8'h00, 8'h80, 8'hFF, 8'h7F, 8'h01,
		8'h00, 8'h00, 8'h01, 8'h55, 8'hAA, 8'hAA, 8'h55, 8'hFE, 8'hFF
	};

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       hold_req = 1'b0;
	logic       steady;
	int         burst_left;
	int         cycle_count;
	int         results_due;
	int         failures;
	logic [7:0] frame_crc;

	tfd_chan_if #(.T(tfd_cfg_t)) cfg_ch ();
	tfd_chan_if #(.T(tfd_in_t))  rx_ch ();
	tfd_chan_if #(.T(tfd_out_t)) res_ch ();

	thermal_frame_deframer_pec_core #(.DATA_BYTES(DATA_BYTES)) DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_ch),
		.rx     (rx_ch),
		.result (res_ch)
	);

	thermal_frame_deframer_pec_check #(.DATA_BYTES(DATA_BYTES)) frame_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_ch.valid),
		.cfg_ready    (cfg_ch.ready),
		.cfg_data     (cfg_ch.data),
		.rx_valid     (rx_ch.valid),
		.rx_ready     (rx_ch.ready),
		.rx_data      (rx_ch.data),
		.result_valid (res_ch.valid),
		.result_ready (res_ch.ready),
		.result_data  (res_ch.data),
		.results_due  (results_due),
		.failures     (failures),
		.frame_crc    (frame_crc)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [7:0] random_byte();
		case ($urandom_range(0, 11))
		0:       return 8'h00;
		1:       return 8'hFF;
		2:       return 8'h80;
		3:       return 8'h7F;
		default: return 8'($urandom);
		endcase
	endfunction

	// called and returns at a falling edge; valid stays up between back-to-back requests
	task automatic put_byte(input logic [7:0] b, input logic start);
		tfd_in_t item;
		if (!steady && burst_left == 0) begin
			rx_ch.valid = 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
			burst_left = $urandom_range(1, 24);
		end
		item.rx_byte = b;
		item.frame_start = start;
		rx_ch.data = item;
		rx_ch.valid = 1'b1;
		@(posedge clk);
		while (!rx_ch.ready)
			@(posedge clk);
		@(negedge clk);
		if (burst_left > 0)
			burst_left--;
	endtask

	task automatic send_frame(input int n_data, input bit with_pec, input bit bad_pec,
			input int n_trail, inout int sent);
		logic [7:0] pec;
		for (int i = 0; i < n_data; i++)
			put_byte(random_byte(), i == 0);
		sent += n_data;
		if (with_pec) begin
			pec = frame_crc;
			if (bad_pec)
				pec = pec ^ 8'($urandom_range(1, 255));
			put_byte(pec, 1'b0);
			sent++;
			for (int i = 0; i < n_trail; i++)
				put_byte(random_byte(), 1'b0);
		end
	endtask

	task automatic drain_results();
		rx_ch.valid = 1'b0;
		while (results_due != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// leaves valid high; caller lowers it after the last write
	task automatic write_reg(input tfd_cfg_idx_t idx, input logic [7:0] v);
		tfd_cfg_t w;
		w.index = idx;
		w.value = v;
		cfg_ch.data = w;
		cfg_ch.valid = 1'b1;
		@(posedge clk);
		while (!cfg_ch.ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	initial begin : result_sink
		int   seg_left;
		int   mode;
		logic hold_done;
		seg_left = 0;
		mode = 0;
		hold_done = 1'b0;
		res_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req && !hold_done) begin
				res_ch.ready = 1'b0;
				repeat (LONG_HOLD - 1) @(negedge clk);
				hold_done = 1'b1;
			end else begin
				if (seg_left == 0) begin
					mode = $urandom_range(0, 3);
					seg_left = $urandom_range(8, 80);
				end
				seg_left--;
				case (mode)
				0:       res_ch.ready = 1'b1;
				1:       res_ch.ready = ($urandom_range(0, 1) == 1);
				2:       res_ch.ready = ($urandom_range(0, 7) != 0);
				default: res_ch.ready = (seg_left % 5 > 1);
				endcase
			end
		end
	end

	initial begin : watchdog
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("CHECKS FAILED");
		$finish;
	end

	initial begin : stimulus
		logic [7:0] phase_addr [PHASES];
		logic [7:0] phase_cmd [PHASES];
		int         sent;
		int         pick;
		cfg_ch.valid = 1'b0;
		cfg_ch.data = '0;
		rx_ch.valid = 1'b0;
		rx_ch.data = '0;
		steady = 1'b0;
		burst_left = 0;
		sent = 0;
		phase_addr = '{8'hFF, 8'h00, 8'hFE, 8'h00, 8'h00, 8'h14};
		phase_cmd = '{8'h00, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h4C};
		phase_addr[3] = 8'($urandom_range(0, 254));
		phase_addr[4] = 8'($urandom_range(0, 254));
		phase_cmd[2] = 8'($urandom);
		phase_cmd[3] = 8'($urandom);
		phase_cmd[4] = 8'($urandom);
		repeat (2) @(negedge clk);
		arst_n = 1'b1;

		// reset configuration: stray byte, open odd-length frame, restart inside it
		put_byte(8'h5A, 1'b0);
		for (int i = 0; i < 3; i++)
			put_byte(random_byte(), i == 0);
		for (int i = 0; i < DATA_BYTES; i++)
			put_byte(EXTREME_BYTES[i], i == 0);
		put_byte(frame_crc, 1'b0);
		put_byte(8'hA5, 1'b0);
		put_byte(8'hFF, 1'b0);

		for (int p = 0; p < PHASES; p++) begin
			drain_results();
			write_reg(CFG_WRITE_ADDR, phase_addr[p]);
			write_reg(CFG_COMMAND, phase_cmd[p]);
			cfg_ch.valid = 1'b0;
			steady = (p == 3);
			if (p == 1)
				hold_req = 1'b1;
			sent = 0;
			while (sent < ITEMS_PER_PHASE) begin
				pick = $urandom_range(0, 19);
				if (pick < 14)
					send_frame(DATA_BYTES, 1'b1, pick < 3, 0, sent);
				else if (pick < 16)
					send_frame(DATA_BYTES, 1'b1, 1'b0, $urandom_range(1, 4), sent);
				else if (pick < 19)
					send_frame($urandom_range(1, DATA_BYTES), 1'b0, 1'b0, 0, sent);
				else
					repeat ($urandom_range(1, 3)) put_byte(random_byte(), 1'b0);
			end
		end

		drain_results();
		if (failures == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

// ===== thermal_frame_deframer_pec_core.f =====
hdl/tfd_pkg.sv
hdl/tfd_chan_if.sv
hdl/tfd_prefix.sv
hdl/thermal_frame_deframer_pec_core.sv
tb/thermal_frame_deframer_pec_check.sv
tb/thermal_frame_deframer_pec_core_test.sv
